### rtl/rmp_pkg.sv
// shared types and constants for the ramp motion profile block
package rmp_pkg;

  localparam int unsigned CfgIdxWidth = 2;
  localparam int unsigned RateWidth   = 31;
  localparam int unsigned FracWidth   = 5;
  localparam int unsigned FracMax     = 16;
  // velocity magnitude bits, square width, divisor width
  localparam int unsigned VelWidth    = 32;
  localparam int unsigned SqWidth     = 64;
  localparam int unsigned DivWidth    = 33;

  typedef enum logic [1:0] {
    CMD_TICK = 2'd0,
    CMD_GOAL = 2'd1,
    CMD_JUMP = 2'd2,
    CMD_NONE = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    REG_MAX_RATE = 2'd0,
    REG_ACCEL    = 2'd1,
    REG_FRAC     = 2'd2,
    REG_MODE     = 2'd3
  } reg_idx_e;

  // control between the sequencer and the serial arithmetic unit
  typedef struct packed {
    logic start;
  } ser_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } ser_stat_t;

endpackage

### rtl/rmp_if.sv
// request channel interfaces for the ramp motion profile block
interface rmp_cmd_if;
  logic                      valid;
  logic                      ready;
  logic [1:0]                command;
  logic signed [31:0]        value;
  modport source (output valid, command, value, input ready);
  modport sink (input valid, command, value, output ready);
endinterface

interface rmp_out_if;
  logic                      valid;
  logic                      ready;
  logic signed [31:0]        position;
  logic                      settled;
  modport source (output valid, position, settled, input ready);
  modport sink (input valid, position, settled, output ready);
endinterface

interface rmp_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [rmp_pkg::CfgIdxWidth-1:0]   index;
  logic [31:0]                       data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

### rtl/ramp_motion_profile.sv
// top level of the ramp motion profile set-point generator
// Each request gives exactly one result of position and settled flag. Goal,
// jump, idle ticks and linear ticks go straight from EXEC to OUT. A trapezoid
// tick that is not settled and not at rest on the goal also passes BRAKE and
// APPLY: the braking distance v*v/(2*accel) comes from a bit-serial unit that
// squares the velocity and then does restoring division, one bit per cycle.
// One request is worked at a time; a result waits in the output register and
// the next request is taken once it has left. Configuration writes are taken
// at any time but are meant for idle periods only.
module ramp_motion_profile #(
  parameter int unsigned POS_WIDTH = 32
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  rmp_cmd_if.sink   cmd_i,
  rmp_cfg_if.sink   cfg_i,
  rmp_out_if.source res_o
);
  localparam int unsigned PW = POS_WIDTH;
  localparam int unsigned DW = PW + 1;       // exact distance width
  localparam int unsigned VW = rmp_pkg::VelWidth;
  localparam int unsigned XW = 36;           // wide signed for velocity math

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_EXEC  = 5'b00010,
    ST_BRAKE = 5'b00100,
    ST_APPLY = 5'b01000,
    ST_OUT   = 5'b10000
  } st_e;

  st_e st_q, st_d;

  logic [rmp_pkg::RateWidth-1:0] max_rate_q, accel_q;
  logic [4:0]                    frac_q;
  logic                          mode_q;

  logic signed [PW-1:0] pos_q, goal_q;
  logic signed [VW-1:0] vel_q;
  logic [15:0]          facc_q;
  logic                 settled_q;
  logic [1:0]           cmd_q;
  logic signed [PW-1:0] val_q;
  logic signed [DW-1:0] diff_q;

  rmp_pkg::ser_ctrl_t          br_ctrl;
  rmp_pkg::ser_stat_t          br_stat;
  logic [rmp_pkg::SqWidth-1:0] quot;
  logic [VW-1:0]               abs_v;

  assign cmd_i.ready = (st_q == ST_IDLE);
  assign cfg_i.ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_rate_q <= rmp_pkg::RateWidth'(1);
      accel_q    <= rmp_pkg::RateWidth'(1);
      frac_q     <= '0;
      mode_q     <= 1'b0;
    end else if (cfg_i.valid) begin
      case (rmp_pkg::reg_idx_e'(cfg_i.index))
        rmp_pkg::REG_MAX_RATE: max_rate_q <= cfg_i.data[rmp_pkg::RateWidth-1:0];
        rmp_pkg::REG_ACCEL:    accel_q    <= cfg_i.data[rmp_pkg::RateWidth-1:0];
        rmp_pkg::REG_FRAC:     frac_q     <= cfg_i.data[4:0];
        rmp_pkg::REG_MODE:     mode_q     <= cfg_i.data[0];
        default: ;
      endcase
    end
  end

  // velocity magnitude for the braking unit
  assign abs_v = vel_q[VW-1] ? VW'(-vel_q) : VW'(vel_q);
  assign br_ctrl.start = (st_q == ST_EXEC) && (rmp_pkg::cmd_e'(cmd_q) == rmp_pkg::CMD_TICK)
                         && !settled_q && mode_q
                         && !(diff_q == '0 && vel_q == '0);

  rmp_brake u_brake (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (br_ctrl),
    .abs_v_i(abs_v),
    .accel_i(accel_q),
    .stat_o (br_stat),
    .quot_o (quot)
  );

  // trapezoid update
  logic [4:0]           fb;
  logic [DW-1:0]        abs_d;
  logic [rmp_pkg::SqWidth-1:0] brake;
  logic                 dir_pos, brk;
  logic signed [XW-1:0] v, vn, acc_x, rate_x, sum_x, whole_x, np_x, nd_x;
  logic [15:0]          mask, low;
  logic signed [PW-1:0] t_pos;
  logic signed [VW-1:0] t_vel;
  logic [15:0]          t_facc;
  logic                 t_set;

  always_comb begin
    fb      = (frac_q > 5'(rmp_pkg::FracMax)) ? 5'(rmp_pkg::FracMax) : frac_q;
    abs_d   = diff_q[DW-1] ? DW'(-diff_q) : DW'(diff_q);
    brake   = (accel_q == '0) ? '0 : (quot >> fb);
    dir_pos = (diff_q > 0);
    v       = XW'(vel_q);
    acc_x   = XW'($unsigned(accel_q));
    rate_x  = XW'($unsigned(max_rate_q));
    brk     = (rmp_pkg::SqWidth'(abs_d) <= brake) || (dir_pos && v < 0)
              || (!dir_pos && v > 0);
    vn = v;
    if (brk) begin
      if (v > 0) begin
        vn = v - acc_x;
        if (vn < 0) vn = '0;
      end else if (v < 0) begin
        vn = v + acc_x;
        if (vn > 0) vn = '0;
      end
    end else begin
      vn = dir_pos ? v + acc_x : v - acc_x;
      if (vn > rate_x) vn = rate_x;
      if (vn < -rate_x) vn = -rate_x;
    end
    mask   = 16'((17'd1 << fb) - 17'd1);
    t_facc = facc_q;
    if (fb != '0) begin
      sum_x   = XW'($unsigned(facc_q)) + vn;
      low     = sum_x[15:0] & mask;
      whole_x = sum_x >>> fb;
      t_facc  = low;
    end else begin
      sum_x   = '0;
      low     = '0;
      whole_x = vn;
    end
    np_x  = XW'(pos_q) + whole_x;
    nd_x  = XW'(goal_q) - np_x;
    t_vel = VW'(vn);
    t_set = settled_q;
    if ((diff_q > 0 && nd_x <= 0) || (diff_q < 0 && nd_x >= 0)) begin
      t_pos  = goal_q;
      t_vel  = '0;
      t_facc = '0;
      t_set  = 1'b1;
    end else begin
      t_pos = PW'(np_x);
    end
  end

  // linear update
  logic signed [XW-1:0] lstep, lrate, ldiff;
  logic signed [PW-1:0] l_pos;
  always_comb begin
    ldiff = XW'(diff_q);
    lrate = XW'($unsigned(max_rate_q));
    if (ldiff > 0) lstep = (ldiff > lrate) ? lrate : ldiff;
    else lstep = (ldiff < -lrate) ? -lrate : ldiff;
    l_pos = PW'(XW'(pos_q) + lstep);
  end

  // sequencer
  always_comb begin
    st_d = st_q;
    case (st_q)
      ST_IDLE:  if (cmd_i.valid) st_d = ST_EXEC;
      ST_EXEC:  st_d = br_ctrl.start ? ST_BRAKE : ST_OUT;
      ST_BRAKE: if (br_stat.done) st_d = ST_APPLY;
      ST_APPLY: st_d = ST_OUT;
      ST_OUT:   if (res_o.ready) st_d = ST_IDLE;
      default:  st_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q      <= ST_IDLE;
      pos_q     <= '0;
      goal_q    <= '0;
      vel_q     <= '0;
      facc_q    <= '0;
      settled_q <= 1'b1;
    end else begin
      st_q <= st_d;
      if (st_q == ST_EXEC) begin
        case (rmp_pkg::cmd_e'(cmd_q))
          rmp_pkg::CMD_GOAL: begin
            goal_q    <= val_q;
            vel_q     <= '0;
            facc_q    <= '0;
            settled_q <= (pos_q == val_q);
          end
          rmp_pkg::CMD_JUMP: begin
            pos_q     <= val_q;
            goal_q    <= val_q;
            vel_q     <= '0;
            facc_q    <= '0;
            settled_q <= 1'b1;
          end
          rmp_pkg::CMD_TICK: begin
            if (!settled_q) begin
              if (!mode_q) begin
                if (diff_q == '0) settled_q <= 1'b1;
                else begin
                  pos_q     <= l_pos;
                  settled_q <= (l_pos == goal_q);
                end
              end else if (diff_q == '0 && vel_q == '0) begin
                facc_q    <= '0;
                settled_q <= 1'b1;
              end
            end
          end
          default: ;
        endcase
      end else if (st_q == ST_APPLY) begin
        pos_q     <= t_pos;
        vel_q     <= t_vel;
        facc_q    <= t_facc;
        settled_q <= t_set;
      end
    end
  end

  // request capture and distance
  always_ff @(posedge clk_i) begin
    if (cmd_i.valid && cmd_i.ready) begin
      cmd_q  <= cmd_i.command;
      val_q  <= PW'(cmd_i.value);
      diff_q <= DW'(goal_q) - DW'(pos_q);
    end
  end

  assign res_o.valid    = (st_q == ST_OUT);
  assign res_o.position = 32'(pos_q);
  assign res_o.settled  = settled_q;
endmodule

### rtl/rmp_brake.sv
// bit-serial braking distance: v*v by shift-add, then restoring division by 2*accel
module rmp_brake (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  rmp_pkg::ser_ctrl_t                  ctrl_i,
  input  logic [rmp_pkg::VelWidth-1:0]        abs_v_i,
  input  logic [rmp_pkg::RateWidth-1:0]       accel_i,
  output rmp_pkg::ser_stat_t                  stat_o,
  output logic [rmp_pkg::SqWidth-1:0]         quot_o
);
  localparam int unsigned SqW  = rmp_pkg::SqWidth;
  localparam int unsigned VW   = rmp_pkg::VelWidth;
  localparam int unsigned DW   = rmp_pkg::DivWidth;
  localparam int unsigned CntW = 7;

  typedef enum logic [2:0] {
    BR_IDLE = 3'b001,
    BR_MUL  = 3'b010,
    BR_DIV  = 3'b100
  } br_state_e;

  br_state_e          state_q, state_d;
  logic [CntW-1:0]    cnt_q, cnt_d;
  logic [VW-1:0]      mplr_q, mplr_d;
  logic [SqW-1:0]     mcand_q, mcand_d;
  logic [SqW-1:0]     acc_q, acc_d;      // product, then quotient bits shift in
  logic [DW:0]        rem_q, rem_d;
  logic [DW-1:0]      dvsr;
  logic [DW:0]        trial;
  logic               done_q, done_d;

  assign dvsr  = {1'b0, accel_i, 1'b0};
  assign trial = {rem_q[DW-1:0], acc_q[SqW-1]};

  // one multiplier bit or one quotient bit per cycle
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    mplr_d  = mplr_q;
    mcand_d = mcand_q;
    acc_d   = acc_q;
    rem_d   = rem_q;
    done_d  = 1'b0;
    case (state_q)
      BR_IDLE: begin
        if (ctrl_i.start) begin
          state_d = BR_MUL;
          mplr_d  = abs_v_i;
          mcand_d = SqW'(abs_v_i);
          acc_d   = '0;
          cnt_d   = '0;
        end
      end
      BR_MUL: begin
        if (mplr_q[0]) acc_d = acc_q + mcand_q;
        mplr_d  = mplr_q >> 1;
        mcand_d = mcand_q << 1;
        cnt_d   = cnt_q + 1'b1;
        if (cnt_q == CntW'(VW - 1)) begin
          state_d = BR_DIV;
          cnt_d   = '0;
          rem_d   = '0;
        end
      end
      BR_DIV: begin
        if (trial >= {1'b0, dvsr}) begin
          rem_d = trial - {1'b0, dvsr};
          acc_d = {acc_q[SqW-2:0], 1'b1};
        end else begin
          rem_d = trial;
          acc_d = {acc_q[SqW-2:0], 1'b0};
        end
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CntW'(SqW - 1)) begin
          state_d = BR_IDLE;
          done_d  = 1'b1;
        end
      end
      default: state_d = BR_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BR_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q   <= cnt_d;
    mplr_q  <= mplr_d;
    mcand_q <= mcand_d;
    acc_q   <= acc_d;
    rem_q   <= rem_d;
  end

  assign stat_o.busy = (state_q != BR_IDLE);
  assign stat_o.done = done_q;
  assign quot_o      = acc_q;
endmodule

### rtl/rmp_checker.sv
// port-level checks for the ramp motion profile block
module rmp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid,
  input logic        in_ready,
  input logic [1:0]  in_cmd,
  input logic [31:0] in_value,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_pos,
  input logic        out_settled
);
  // a held result keeps its payload
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(out_pos) && $stable(out_settled))
    else $error("result changed while stalled");

  // no new request while a result waits
  a_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> !in_ready)
    else $error("request taken while result pending");

  // a jump always settles
  a_jump: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready && in_cmd == rmp_pkg::CMD_JUMP ##3 out_valid |-> out_settled)
    else $error("jump did not settle");

  // jump reports its value
  a_jpos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready && in_cmd == rmp_pkg::CMD_JUMP |-> ##3 (out_pos == $past(in_value, 3)))
    else $error("jump position wrong");
endmodule

bind ramp_motion_profile rmp_checker u_rmp_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid   (cmd_i.valid),
  .in_ready   (cmd_i.ready),
  .in_cmd     (cmd_i.command),
  .in_value   (cmd_i.value),
  .out_valid  (res_o.valid),
  .out_ready  (res_o.ready),
  .out_pos    (res_o.position),
  .out_settled(res_o.settled)
);

### tb/sv/ramp_motion_profile_tb.sv
// self-checking testbench for the ramp motion profile set-point generator
`timescale 1ns / 100ps

module ramp_motion_profile_tb;

  localparam int unsigned StallLimit = 20000;

  typedef struct {
    logic signed [31:0] position;
    logic               settled;
  } sample_t;

  // scoreboard: predicts position and settled flag per accepted request
  class ramp_scoreboard;
    longint unsigned rate_q, accel_q, frac_q;
    bit              trap_q;
    longint          pos_q, goal_q, vel_q, frac_acc_q;
    bit              settled_q;
    sample_t         pending_q[$];
    int              errors;

    function void reset_state();
      rate_q = 1; accel_q = 1; frac_q = 0; trap_q = 0;
      pos_q = 0; goal_q = 0; vel_q = 0; frac_acc_q = 0; settled_q = 1;
      errors = 0;
    endfunction

    function void write_reg(rmp_pkg::reg_idx_e idx, logic [31:0] data);
      case (idx)
        rmp_pkg::REG_MAX_RATE: rate_q = data[30:0];
        rmp_pkg::REG_ACCEL:    accel_q = data[30:0];
        rmp_pkg::REG_FRAC:     frac_q = data[4:0];
        rmp_pkg::REG_MODE:     trap_q = data[0];
        default: ;
      endcase
    endfunction

    function longint wrap32(longint x);
      logic signed [31:0] w;
      w = x[31:0];
      return longint'(w);
    endfunction

    function void linear_tick();
      longint delta;
      longint lim;
      delta = goal_q - pos_q;
      lim = longint'(rate_q);
      if (delta == 0) begin
        settled_q = 1;
        return;
      end
      if (delta > 0) pos_q += (delta > lim) ? lim : delta;
      else pos_q += (delta < -lim) ? -lim : delta;
      pos_q = wrap32(pos_q);
      settled_q = (pos_q == goal_q);
    endfunction

    function void trapezoid_tick();
      longint delta, acc, lim, target, sum, low, whole, rem;
      longint unsigned mag_v, mag_d, brake;
      int unsigned fb;
      bit fwd;
      delta = goal_q - pos_q;
      acc = longint'(accel_q);
      lim = longint'(rate_q);
      fb = (frac_q > rmp_pkg::FracMax) ? rmp_pkg::FracMax : int'(frac_q);
      brake = 0;
      if (delta == 0 && vel_q == 0) begin
        frac_acc_q = 0;
        settled_q = 1;
        return;
      end
      fwd = (delta > 0);
      mag_v = (vel_q < 0) ? -vel_q : vel_q;
      mag_d = (delta < 0) ? -delta : delta;
      if (acc > 0) brake = ((mag_v * mag_v) / (2 * longint'(acc))) >> fb;
      // brake when close enough or moving away from the goal
      if (mag_d <= brake || (fwd && vel_q < 0) || (!fwd && vel_q > 0)) begin
        if (vel_q > 0) begin
          vel_q -= acc;
          if (vel_q < 0) vel_q = 0;
        end else if (vel_q < 0) begin
          vel_q += acc;
          if (vel_q > 0) vel_q = 0;
        end
      end else begin
        vel_q += fwd ? acc : -acc;
        if (vel_q > lim) vel_q = lim;
        if (vel_q < -lim) vel_q = -lim;
      end
      // whole units leave the fraction accumulator
      if (fb > 0) begin
        sum = frac_acc_q + vel_q;
        low = sum & ((64'sd1 << fb) - 1);
        whole = (sum - low) / (64'sd1 << fb);
        frac_acc_q = low;
        target = pos_q + whole;
      end else begin
        target = pos_q + vel_q;
      end
      rem = goal_q - target;
      if ((delta > 0 && rem <= 0) || (delta < 0 && rem >= 0)) begin
        pos_q = goal_q;
        vel_q = 0;
        frac_acc_q = 0;
        settled_q = 1;
      end else begin
        pos_q = wrap32(target);
      end
    endfunction

    function void note_request(logic [1:0] cmd, logic signed [31:0] val);
      sample_t s;
      if (cmd == rmp_pkg::CMD_GOAL) begin
        goal_q = val; vel_q = 0; frac_acc_q = 0;
        settled_q = (pos_q == goal_q);
      end else if (cmd == rmp_pkg::CMD_JUMP) begin
        pos_q = val; goal_q = val; vel_q = 0; frac_acc_q = 0; settled_q = 1;
      end else if (cmd == rmp_pkg::CMD_TICK && !settled_q) begin
        if (trap_q) trapezoid_tick();
        else linear_tick();
      end
      s.position = pos_q[31:0];
      s.settled = settled_q;
      pending_q.push_back(s);
    endfunction

    function void check_result(logic signed [31:0] pos, logic stl);
      sample_t s;
      if (pending_q.size() == 0) begin
        $error("unexpected result position %0d settled %0b", pos, stl);
        errors++;
        return;
      end
      s = pending_q.pop_front();
      if (pos !== s.position) begin
        $error("position expected %0d actual %0d", s.position, pos);
        errors++;
      end
      if (stl !== s.settled) begin
        $error("settled expected %0b actual %0b", s.settled, stl);
        errors++;
      end
    endfunction
  endclass

  logic clk_i = 0;
  logic rst_ni = 0;
  rmp_cmd_if cmd_if();
  rmp_out_if out_if();
  rmp_cfg_if cfg_if();
  ramp_scoreboard sb = new();
  int idle_cycles;
  bit hold_rx;

  always begin
    #5 clk_i = 1;
    #5 clk_i = 0;
  end

  ramp_motion_profile DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cmd_i (cmd_if.sink),
    .cfg_i (cfg_if.sink),
    .res_o (out_if.source)
  );

  // note requests and check results at the rising edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cmd_if.valid && cmd_if.ready) sb.note_request(cmd_if.command, cmd_if.value);
      if (out_if.valid && out_if.ready) sb.check_result(out_if.position, out_if.settled);
      if ((cmd_if.valid && cmd_if.ready) || (out_if.valid && out_if.ready) ||
          (cfg_if.valid && cfg_if.ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if (idle_cycles >= StallLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    int gap;
    out_if.ready = 0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_rx) begin
        out_if.ready <= 0;
        repeat (300) @(negedge clk_i);
        hold_rx = 0;
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
        out_if.ready <= 0;
        repeat (gap - 1) @(negedge clk_i);
        @(negedge clk_i);
      end
      out_if.ready <= 1;
      do @(posedge clk_i); while (!out_if.valid);
    end
  end

  task automatic write_cfg(rmp_pkg::reg_idx_e idx, logic [31:0] data);
    @(negedge clk_i);
    cfg_if.valid <= 1;
    cfg_if.index <= idx;
    cfg_if.data <= data;
    do @(posedge clk_i); while (!cfg_if.ready);
    sb.write_reg(idx, data);
    @(negedge clk_i);
    cfg_if.valid <= 0;
  endtask

  task automatic send_cmd(rmp_pkg::cmd_e cmd, logic [31:0] val, bit no_gap = 0);
    int gap;
    gap = no_gap ? 0 : (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6));
    @(negedge clk_i);
    if (gap > 0) begin
      cmd_if.valid <= 0;
      repeat (gap) @(negedge clk_i);
    end
    cmd_if.valid <= 1;
    cmd_if.command <= cmd;
    cmd_if.value <= val;
    do @(posedge clk_i); while (!cmd_if.ready);
  endtask

  task automatic drain();
    @(negedge clk_i);
    cmd_if.valid <= 0;
    while (sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (120) @(posedge clk_i);
  endtask

  task automatic configure(logic [31:0] rate, logic [31:0] acc, logic [31:0] fb, bit mode);
    write_cfg(rmp_pkg::REG_MAX_RATE, rate);
    write_cfg(rmp_pkg::REG_ACCEL, acc);
    write_cfg(rmp_pkg::REG_FRAC, fb);
    write_cfg(rmp_pkg::REG_MODE, mode);
  endtask

  function automatic logic [31:0] near_goal();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return sb.pos_q[31:0] + $urandom_range(0, 200) - 100;
      2: return sb.pos_q[31:0] + $urandom_range(0, 4000) - 2000;
      default: return {$urandom_range(0, 1) ? 32'h8000_0000 : 32'h7fff_ff00} +
                      $urandom_range(0, 255);
    endcase
  endfunction

  // one random phase: mostly ticks, with some goals, jumps and idle commands
  task automatic random_phase(int count);
    int n;
    int unsigned r;
    n = 0;
    while (n < count) begin
      r = $urandom_range(0, 19);
      if (r < 3) send_cmd(rmp_pkg::CMD_GOAL, near_goal());
      else if (r == 3) send_cmd(rmp_pkg::CMD_JUMP, $urandom);
      else if (r == 4) send_cmd(rmp_pkg::CMD_NONE, $urandom);
      else send_cmd(rmp_pkg::CMD_TICK, $urandom);
      n++;
    end
    drain();
  endtask

  initial begin
    cmd_if.valid = 0; cmd_if.command = rmp_pkg::CMD_TICK; cmd_if.value = 0;
    cfg_if.valid = 0; cfg_if.index = rmp_pkg::REG_MAX_RATE; cfg_if.data = 0;
    idle_cycles = 0; hold_rx = 0;
    sb.reset_state();
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1;

    // directed: reset defaults, field extremes, every command
    send_cmd(rmp_pkg::CMD_TICK, 32'hffff_ffff);
    send_cmd(rmp_pkg::CMD_GOAL, 32'd3);
    repeat (4) send_cmd(rmp_pkg::CMD_TICK, 0);
    send_cmd(rmp_pkg::CMD_NONE, 32'h1234_5678);
    send_cmd(rmp_pkg::CMD_JUMP, 32'h7fff_fffe);
    send_cmd(rmp_pkg::CMD_GOAL, 32'h8000_0000);
    drain();
    configure(32'h7fff_ffff, 32'h7fff_ffff, 32'd0, 0);
    send_cmd(rmp_pkg::CMD_TICK, 0);
    send_cmd(rmp_pkg::CMD_GOAL, 32'h7fff_ffff);
    send_cmd(rmp_pkg::CMD_TICK, 0);
    send_cmd(rmp_pkg::CMD_TICK, 0);
    drain();
    // zero rate stays unsettled; then trapezoid with zero accel
    configure(32'h0, 32'h0, 32'd31, 0);
    send_cmd(rmp_pkg::CMD_GOAL, 32'd10);
    send_cmd(rmp_pkg::CMD_TICK, 0);
    drain();
    write_cfg(rmp_pkg::REG_MODE, 1);
    send_cmd(rmp_pkg::CMD_TICK, 0);
    send_cmd(rmp_pkg::CMD_JUMP, 0);
    drain();
    // trapezoid overshoot and zero-distance with velocity
    configure(32'd50, 32'd7, 32'd0, 1);
    send_cmd(rmp_pkg::CMD_GOAL, 32'd100);
    repeat (6) send_cmd(rmp_pkg::CMD_TICK, 0);
    drain();

    // random phases across settings; long output hold-off in the second
    configure(32'd5, 32'd1, 32'd0, 0);
    random_phase(100);
    configure(32'd64, 32'd4, 32'd4, 1);
    hold_rx = 1;
    random_phase(100);
    configure(32'd3000, 32'd700, 32'd8, 1);
    random_phase(100);
    configure(32'h7fff_ffff, 32'h7fff_ffff, 32'd16, 1);
    random_phase(100);
    configure(32'd1, 32'd1, 32'd16, 1);
    random_phase(80);
    configure($urandom_range(1, 1 << 20), $urandom_range(1, 1 << 16),
              $urandom_range(0, 31), 1);
    random_phase(120);
    configure(32'h7fff_ffff, 32'd1, 32'd0, 0);
    random_phase(100);
    configure($urandom, $urandom, $urandom, 1'($urandom));
    random_phase(100);

    if (sb.errors == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end
endmodule

### filelist.f
rtl/rmp_pkg.sv
rtl/rmp_if.sv
rtl/rmp_brake.sv
rtl/ramp_motion_profile.sv
rtl/rmp_checker.sv
tb/sv/ramp_motion_profile_tb.sv
